// ===== rtl/core/asd_pkg.sv =====
package asd_pkg;

	localparam int IP_ENTRIES  = 64;
	localparam int MAC_ENTRIES = 64;
	localparam int IP_SLOTS    = 4;
	localparam int IP_AW       = $clog2(IP_ENTRIES);
	localparam int MAC_AW      = $clog2(MAC_ENTRIES);
	localparam int SLOT_AW     = $clog2(IP_SLOTS);
	localparam int CNT_W       = $clog2(IP_SLOTS + 1);
	localparam int SLOTS_AW    = MAC_AW + SLOT_AW;

	localparam logic [15:0] ETH_ARP    = 16'h0806;
	localparam logic [15:0] HW_ETHER   = 16'h0001;
	localparam logic [15:0] PROTO_IPV4 = 16'h0800;
	localparam logic [7:0]  HW_LEN     = 8'd6;
	localparam logic [7:0]  PROTO_LEN  = 8'd4;
	localparam logic [15:0] OP_REQUEST = 16'd1;
	localparam logic [15:0] OP_REPLY   = 16'd2;

	localparam logic [1:0] CLS_REQUEST = 2'd0;
	localparam logic [1:0] CLS_REPLY   = 2'd1;
	localparam logic [1:0] CLS_OTHER   = 2'd2;

	localparam logic [15:0] MIN_LEN_RESET = 16'd42;
	localparam logic [1:0]  LIMIT_RESET   = 2'd2;

	localparam logic REG_MIN_LEN = 1'b0;
	localparam logic REG_LIMIT   = 1'b1;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic        is_arp;
		logic [1:0]  cls;
		logic [47:0] mac;
		logic [31:0] ip;
	} job_t;

	typedef struct packed {
		logic        is_arp;
		logic [1:0]  opcode_class;
		logic        spoof_alert;
		logic [47:0] previous_mac;
		logic        multi_ip_warning;
		logic [2:0]  ips_for_mac;
		logic        ip_table_full;
		logic        mac_table_full;
	} res_t;

endpackage

// ===== rtl/core/arp_spoof_detector.sv =====
// Channel  | Signals                              | Handshake
// request  | start, busy, frame fields            | taken when start & !busy
// result   | done, result fields                  | one-cycle strobe on done
// config   | psel penable pwrite paddr pwdata ... | APB write, pready tied high
//
// Requests are classified in the front and queued (two deep); the back end
// scans the IP table then the MAC table one entry per cycle through the
// registered memory read port, then compares the IP slots stored for the
// MAC; a non-ARP request skips the scans. busy is high while the queue is
// full.
// Reset clears the valid bits and counts at once; no clearing pass.
// done cannot be stalled by the receiver.
module arp_spoof_detector (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [15:0] frame_length,
	input  logic [15:0] ether_kind,
	input  logic [15:0] hardware_kind,
	input  logic [15:0] protocol_kind,
	input  logic [7:0]  hardware_size,
	input  logic [7:0]  protocol_size,
	input  logic [15:0] operation,
	input  logic [47:0] sender_hw_addr,
	input  logic [31:0] sender_proto_addr,
	output logic        done,
	output logic        is_arp,
	output logic [1:0]  opcode_class,
	output logic        spoof_alert,
	output logic [47:0] previous_mac,
	output logic        multi_ip_warning,
	output logic [2:0]  ips_for_mac,
	output logic        ip_table_full,
	output logic        mac_table_full,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import asd_pkg::*;

	logic [15:0] min_len_q;
	logic [1:0]  limit_q;
	logic q_full, q_valid, pop, res_valid;
	job_t q_head;
	res_t res;

	// register file: word address 0 = min length, 1 = IP limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= MIN_LEN_RESET;
			limit_q   <= LIMIT_RESET;
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_MIN_LEN) begin
			min_len_q <= pwdata[15:0];
		end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == REG_LIMIT) begin
			limit_q <= pwdata[1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[1:0] == 2'b00) begin
			unique case (paddr[2])
				REG_MIN_LEN: prdata = {16'd0, min_len_q};
				REG_LIMIT:   prdata = {30'd0, limit_q};
				default:     prdata = '0;
			endcase
		end
	end
	assign pready = 1'b1;
	assign busy = q_full;

	asd_front u_front (
		.clk, .arst_n,
		.take(start && !q_full),
		.min_len(min_len_q),
		.frame_length, .ether_kind, .hardware_kind, .protocol_kind,
		.hardware_size, .protocol_size, .operation,
		.sender_hw_addr, .sender_proto_addr,
		.pop, .q_full, .q_valid, .q_head
	);

	asd_back u_back (
		.clk, .arst_n, .q_valid, .q_head, .limit(limit_q),
		.pop, .res_valid, .res
	);

	assign done = res_valid;
	assign is_arp = res.is_arp;
	assign opcode_class = res.opcode_class;
	assign spoof_alert = res.spoof_alert;
	assign previous_mac = res.previous_mac;
	assign multi_ip_warning = res.multi_ip_warning;
	assign ips_for_mac = res.ips_for_mac;
	assign ip_table_full = res.ip_table_full;
	assign mac_table_full = res.mac_table_full;
endmodule

// ===== rtl/core/asd_front.sv =====
module asd_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [15:0]        min_len,
	input  logic [15:0]        frame_length,
	input  logic [15:0]        ether_kind,
	input  logic [15:0]        hardware_kind,
	input  logic [15:0]        protocol_kind,
	input  logic [7:0]         hardware_size,
	input  logic [7:0]         protocol_size,
	input  logic [15:0]        operation,
	input  logic [47:0]        sender_hw_addr,
	input  logic [31:0]        sender_proto_addr,
	input  logic               pop,
	output logic               q_full,
	output logic               q_valid,
	output asd_pkg::job_t      q_head
);
	import asd_pkg::*;

	job_t job;
	job_t q_mem_q [QDEPTH];
	logic q_wp_q, q_rp_q;
	logic [1:0] q_cnt_q;

	always_comb begin
		job.is_arp = (frame_length >= min_len) && (ether_kind == ETH_ARP)
			&& (hardware_kind == HW_ETHER) && (protocol_kind == PROTO_IPV4)
			&& (hardware_size == HW_LEN) && (protocol_size == PROTO_LEN);
		job.cls = (operation == OP_REQUEST) ? CLS_REQUEST :
			(operation == OP_REPLY) ? CLS_REPLY : CLS_OTHER;
		job.mac = sender_hw_addr;
		job.ip  = sender_proto_addr;
	end

	always_ff @(posedge clk) begin
		if (take) q_mem_q[q_wp_q] <= job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wp_q  <= 1'b0;
			q_rp_q  <= 1'b0;
			q_cnt_q <= 2'd0;
		end else begin
			if (take) q_wp_q <= ~q_wp_q;
			if (pop) q_rp_q <= ~q_rp_q;
			q_cnt_q <= q_cnt_q + {1'b0, take} - {1'b0, pop};
		end
	end

	assign q_full  = (q_cnt_q == 2'(QDEPTH));
	assign q_valid = (q_cnt_q != 2'd0);
	assign q_head  = q_mem_q[q_rp_q];
endmodule

// ===== rtl/core/asd_back.sv =====
module asd_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  asd_pkg::job_t      q_head,
	input  logic [1:0]         limit,
	output logic               pop,
	output logic               res_valid,
	output asd_pkg::res_t      res
);
	import asd_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_IPSCN = 7'b0000010,
		S_IPUPD = 7'b0000100,
		S_MSCN  = 7'b0001000,
		S_SLOT  = 7'b0010000,
		S_FIN   = 7'b0100000,
		S_OUT   = 7'b1000000
	} st_t;

	st_t st_q;
	job_t job_q;

	logic [31:0] ip_key_mem   [IP_ENTRIES];
	logic [47:0] ip_mac_mem   [IP_ENTRIES];
	logic [47:0] mac_key_mem  [MAC_ENTRIES];
	logic [31:0] slot_mem     [MAC_ENTRIES * IP_SLOTS];
	logic [IP_ENTRIES-1:0]  ip_valid_q;
	logic [MAC_ENTRIES-1:0] mac_valid_q;
	logic [CNT_W-1:0] mac_cnt_q [MAC_ENTRIES];

	logic [IP_AW:0]  ii_q;
	logic [MAC_AW:0] mi_q;
	logic [SLOT_AW:0] si_q;
	logic [31:0] ip_rd_q;
	logic [47:0] ipm_rd_q, mk_rd_q;
	logic [31:0] sl_rd_q;
	logic rd_ok_q;

	// valid bit and index of the entry whose data sits in the read register
	logic ip_rv_q, mac_rv_q;
	logic [IP_AW-1:0]  ip_ridx_q;
	logic [MAC_AW-1:0] mac_ridx_q;
	logic [47:0] ip_hmac_q;

	logic ip_hit_q, ip_free_q, mac_hit_q, mac_free_q, seen_q;
	logic [IP_AW-1:0]  ip_hidx_q, ip_fidx_q;
	logic [MAC_AW-1:0] mac_hidx_q, mac_fidx_q;
	logic [CNT_W-1:0] cnt_q;
	res_t res_q;

	logic [IP_AW-1:0]  ii;
	logic [MAC_AW-1:0] mi, midx;
	logic [SLOT_AW-1:0] si;
	logic [SLOTS_AW-1:0] saddr;
	logic [CNT_W-1:0] c_sat;

	assign ii = ii_q[IP_AW-1:0];
	assign mi = mi_q[MAC_AW-1:0];
	assign si = si_q[SLOT_AW-1:0];
	assign midx = mac_hit_q ? mac_hidx_q : mac_fidx_q;
	assign saddr = {midx, si};
	assign c_sat = (cnt_q > CNT_W'(IP_SLOTS)) ? CNT_W'(IP_SLOTS) : cnt_q;

	// registered reads, one entry per cycle
	always_ff @(posedge clk) begin
		ip_rd_q  <= ip_key_mem[ii];
		ipm_rd_q <= ip_mac_mem[ii];
		mk_rd_q  <= mac_key_mem[mi];
		sl_rd_q  <= slot_mem[saddr];
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && q_valid) job_q <= q_head;
		if (st_q == S_IPUPD && job_q.is_arp) begin
			if (ip_hit_q) ip_mac_mem[ip_hidx_q] <= job_q.mac;
			else if (ip_free_q) begin
				ip_key_mem[ip_fidx_q] <= job_q.ip;
				ip_mac_mem[ip_fidx_q] <= job_q.mac;
			end
		end
		if (st_q == S_SLOT && !rd_ok_q && !seen_q && si_q < (SLOT_AW+1)'(IP_SLOTS)
				&& (si_q == {1'b0, c_sat[SLOT_AW-1:0]} || c_sat == CNT_W'(IP_SLOTS))
				&& c_sat < CNT_W'(IP_SLOTS))
			slot_mem[saddr] <= job_q.ip;
		if (st_q == S_MSCN && mi_q == (MAC_AW+1)'(MAC_ENTRIES) && !rd_ok_q
				&& !mac_hit_q && mac_free_q)
			mac_key_mem[mac_fidx_q] <= job_q.mac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ip_valid_q <= '0;
			mac_valid_q <= '0;
			for (int k = 0; k < MAC_ENTRIES; k++) mac_cnt_q[k] <= '0;
			ii_q <= '0; mi_q <= '0; si_q <= '0; rd_ok_q <= 1'b0;
			ip_rv_q <= 1'b0; mac_rv_q <= 1'b0; ip_ridx_q <= '0; mac_ridx_q <= '0;
			ip_hmac_q <= '0;
			ip_hit_q <= 1'b0; ip_free_q <= 1'b0; mac_hit_q <= 1'b0;
			mac_free_q <= 1'b0; seen_q <= 1'b0;
			ip_hidx_q <= '0; ip_fidx_q <= '0; mac_hidx_q <= '0; mac_fidx_q <= '0;
			cnt_q <= '0;
			res_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (q_valid) begin
						ii_q <= '0; rd_ok_q <= 1'b0;
						ip_hit_q <= 1'b0; ip_free_q <= 1'b0;
						mac_hit_q <= 1'b0; mac_free_q <= 1'b0; seen_q <= 1'b0;
						st_q <= q_head.is_arp ? S_IPSCN : S_FIN;
					end
				end
				S_IPSCN: begin
					// data read at ii_q-1 is valid when rd_ok_q
					if (ii_q != (IP_AW+1)'(IP_ENTRIES)) begin
						if (!ip_valid_q[ii] && !ip_free_q) begin
							ip_free_q <= 1'b1; ip_fidx_q <= ii;
						end
						ip_rv_q <= ip_valid_q[ii];
						ip_ridx_q <= ii;
						ii_q <= ii_q + 1'b1;
					end
					rd_ok_q <= (ii_q != (IP_AW+1)'(IP_ENTRIES));
					if (rd_ok_q && !ip_hit_q && ip_rv_q && ip_rd_q == job_q.ip) begin
						ip_hit_q <= 1'b1;
						ip_hidx_q <= ip_ridx_q;
						ip_hmac_q <= ipm_rd_q;
					end
					if (!rd_ok_q && ii_q == (IP_AW+1)'(IP_ENTRIES))
						st_q <= S_IPUPD;
				end
				S_IPUPD: begin
					res_q.is_arp <= 1'b1;
					res_q.opcode_class <= job_q.cls;
					res_q.spoof_alert <= 1'b0;
					res_q.previous_mac <= '0;
					res_q.ip_table_full <= 1'b0;
					if (ip_hit_q) begin
						if (ip_hmac_q != job_q.mac) begin
							res_q.spoof_alert <= 1'b1;
							res_q.previous_mac <= ip_hmac_q;
						end
					end else if (ip_free_q) ip_valid_q[ip_fidx_q] <= 1'b1;
					else res_q.ip_table_full <= 1'b1;
					mi_q <= '0; rd_ok_q <= 1'b0;
					st_q <= S_MSCN;
				end
				S_MSCN: begin
					if (mi_q != (MAC_AW+1)'(MAC_ENTRIES)) begin
						if (!mac_valid_q[mi] && !mac_free_q) begin
							mac_free_q <= 1'b1; mac_fidx_q <= mi;
						end
						mac_rv_q <= mac_valid_q[mi];
						mac_ridx_q <= mi;
						mi_q <= mi_q + 1'b1;
					end
					rd_ok_q <= (mi_q != (MAC_AW+1)'(MAC_ENTRIES));
					if (rd_ok_q && !mac_hit_q && mac_rv_q && mk_rd_q == job_q.mac) begin
						mac_hit_q <= 1'b1;
						mac_hidx_q <= mac_ridx_q;
					end
					if (!rd_ok_q && mi_q == (MAC_AW+1)'(MAC_ENTRIES)) begin
						si_q <= '0;
						if (mac_hit_q) cnt_q <= mac_cnt_q[mac_hidx_q];
						else if (mac_free_q) begin
							mac_valid_q[mac_fidx_q] <= 1'b1;
							cnt_q <= '0;
						end
						if (mac_hit_q || mac_free_q) begin
							res_q.mac_table_full <= 1'b0;
							st_q <= S_SLOT;
						end else begin
							res_q.mac_table_full <= 1'b1;
							cnt_q <= '0;
							st_q <= S_FIN;
						end
					end
				end
				S_SLOT: begin
					// compare the slots below the count one after another, stopping at a match
					if (rd_ok_q) begin
						if (sl_rd_q == job_q.ip) seen_q <= 1'b1;
						rd_ok_q <= 1'b0;
					end else if ({1'b0, si_q} < {1'b0, c_sat} && !seen_q) begin
						rd_ok_q <= 1'b1;
						si_q <= si_q + 1'b1;
					end else begin
						if (!seen_q && c_sat < CNT_W'(IP_SLOTS)) begin
							cnt_q <= c_sat + 1'b1;
							mac_cnt_q[midx] <= c_sat + 1'b1;
						end else begin
							cnt_q <= c_sat;
							mac_cnt_q[midx] <= c_sat;
						end
						st_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!job_q.is_arp) res_q <= '0;
					else begin
						res_q.ips_for_mac <= (cnt_q > CNT_W'(7)) ? 3'd7 : 3'(cnt_q);
						res_q.multi_ip_warning <= (cnt_q > CNT_W'(limit));
					end
					st_q <= S_OUT;
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign pop = (st_q == S_IDLE) && q_valid;
	assign res_valid = (st_q == S_OUT);
	assign res = res_q;
endmodule
